@@ rtl/ebs_pkg.sv @@
// Shared types, constants and command/status structs of the eye blink sequencer.
// Used by every module of the block; depends on nothing.
package ebs_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned LEN_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_W      = 80;
  localparam int unsigned PROD_W    = 64;

  // Ramp divider: quotient bits below the saturation threshold
  localparam int unsigned QUO_W     = 33;
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W + 1);

  // Multiply by reciprocal of five, then shift
  localparam logic [DATA_W-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP5_SHIFT = 34;

  localparam logic [LEN_W-1:0]  BLINK_LENGTH_RST = 31'd65536;
  localparam logic [DATA_W-1:0] S32_MAX          = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN          = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WAIT_RST         = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLINK_ENABLE = 3'd0,
    CFG_BEGIN_FRAME  = 3'd1,
    CFG_END_FRAME    = 3'd2,
    CFG_INTERVAL_MIN = 3'd3,
    CFG_INTERVAL_MAX = 3'd4,
    CFG_BLINK_LENGTH = 3'd5
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CLOSING = 2'd1,
    PH_HOLD    = 2'd2,
    PH_OPENING = 2'd3
  } blink_phase_e;

  typedef enum logic [1:0] {
    MUL_RELOAD = 2'd0,
    MUL_RAMP   = 2'd1,
    MUL_HOLD   = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_EVAL,
    CS_PRE,
    CS_RLD_MUL,
    CS_RLD_WR,
    CS_WAIT_STEP,
    CS_HOLD_STEP,
    CS_RMP_MUL,
    CS_RMP_CHK,
    CS_RMP_DIV,
    CS_RMP_UPD,
    CS_HLD_MUL,
    CS_HLD_WR,
    CS_RESULT
  } ctl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic     in_load;
    logic     eval;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     reload_wr;
    logic     wait_step;
    logic     hold_step;
    logic     div_start;
    logic     ramp_upd;
    logic     hold_wr;
    logic     res_load;
  } ebs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic         enable;
    logic         supp;
    logic         dt_pos;
    blink_phase_e phase;
    logic         reload_pend;
    logic         hold_expire;
    logic         ramp_big;
    logic         ramp_arrive;
    logic         div_busy;
    logic         out_busy;
  } ebs_stat_t;

endpackage

@@ rtl/ebs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the blink ramp step.
// Depends on ebs_pkg for widths.
module ebs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ebs_pkg::LEN_W-1:0]    rem_i,
  input  logic [ebs_pkg::QUO_W-1:0]    dividend_i,
  input  logic [ebs_pkg::LEN_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [ebs_pkg::QUO_W-1:0]    quotient_o
);

  logic [ebs_pkg::LEN_W-1:0]     rem_q, rem_d;
  logic [ebs_pkg::QUO_W-1:0]     quo_q, quo_d;
  logic [ebs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ebs_pkg::LEN_W:0]       trial;
  logic [ebs_pkg::LEN_W+1:0]     diff;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  // Shift in the next dividend bit and subtract the divisor if it fits
  always_comb begin
    trial = {rem_q, quo_q[ebs_pkg::QUO_W-1]};
    diff  = {1'b0, trial} - {2'b00, divisor_i};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = rem_i;
      quo_d = dividend_i;
      cnt_d = ebs_pkg::DIV_CNT_W'(ebs_pkg::QUO_W);
    end else if (busy_o) begin
      if (!diff[ebs_pkg::LEN_W+1]) begin
        rem_d = diff[ebs_pkg::LEN_W-1:0];
      end else begin
        rem_d = trial[ebs_pkg::LEN_W-1:0];
      end
      quo_d = {quo_q[ebs_pkg::QUO_W-2:0], ~diff[ebs_pkg::LEN_W+1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

`ifndef SYNTHESIS
  // A started division is running in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_o)
    else $error("divider not busy after start");
`endif

endmodule

@@ rtl/ebs_datapath.sv @@
// Datapath of the eye blink sequencer: configuration registers, blink state,
// shared multiplier, ramp divider and output register. Depends on ebs_pkg, ebs_div.
module ebs_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ebs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ebs_pkg::DATA_W-1:0]       cfg_data_i,
  // request payload: time_step, seen_value, random_unit
  input  logic [ebs_pkg::IN_W-1:0]         in_data_i,
  // result
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ebs_pkg::DATA_W-1:0]       out_data_o,
  output logic                             out_pub_o,
  // controller link
  input  ebs_pkg::ebs_cmd_t                cmd_i,
  output ebs_pkg::ebs_stat_t               stat_o
);

  // Configuration
  logic                            blink_enable_q;
  logic signed [ebs_pkg::DATA_W-1:0] begin_frame_q, end_frame_q;
  logic [ebs_pkg::LEN_W-1:0]       interval_min_q, interval_max_q, blink_length_q;

  // Derived spans, refreshed every cycle from the configuration
  logic [ebs_pkg::DATA_W-1:0]      span_mag_q;
  logic                            span_neg_q;
  logic [ebs_pkg::LEN_W-1:0]       range_mag_q;
  logic                            range_neg_q;
  logic [ebs_pkg::DATA_W:0]        span_full;
  logic [ebs_pkg::DATA_W-1:0]      range_full;

  // Request registers
  logic signed [ebs_pkg::DATA_W-1:0] time_step_q, seen_value_q;
  logic [ebs_pkg::UNIT_W-1:0]        random_unit_q;

  // Blink state
  ebs_pkg::blink_phase_e             phase_q;
  logic signed [ebs_pkg::DATA_W-1:0] cur_q, wait_q, hold_q, last_q;
  logic                              supp_q, has_out_q, reload_pend_q;

  // Multiplier
  logic [ebs_pkg::DATA_W-1:0]      mul_a, mul_b;
  logic [ebs_pkg::PROD_W-1:0]      product_q;

  // Output register
  logic                            out_valid_q, out_pub_q;
  logic [ebs_pkg::DATA_W-1:0]      out_data_q;

  // Evaluation of the seen value
  logic                              seen_is_begin, seen_is_last;
  logic                              ev_supp, ev_reload;
  ebs_pkg::blink_phase_e             ev_phase;
  logic signed [ebs_pkg::DATA_W-1:0] ev_cur;

  // Step arithmetic
  logic                              dt_pos;
  logic signed [ebs_pkg::DATA_W-1:0] wait_next, hold_next;
  logic                              wait_expire, hold_expire;
  logic [46:0]                       rl_mag;
  logic [47:0]                       rl_prod;
  logic [ebs_pkg::DATA_W-1:0]        wait_new;

  // Ramp arithmetic
  logic [ebs_pkg::LEN_W-1:0]         len;
  logic                              ramp_big, opening, add_pos;
  logic [ebs_pkg::QUO_W-1:0]         quotient;
  logic                              div_busy;
  logic [34:0]                       cur_ext, quo_ext, ramp_sum;
  logic signed [ebs_pkg::DATA_W-1:0] ramp_next;
  logic                              at_end_v, at_begin_v, ramp_arrive;

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? ebs_pkg::S32_MIN : ebs_pkg::S32_MAX;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

  function automatic logic [31:0] sat35(input logic [34:0] v);
    if (v[34:31] != {4{v[34]}}) begin
      sat35 = v[34] ? ebs_pkg::S32_MIN : ebs_pkg::S32_MAX;
    end else begin
      sat35 = v[31:0];
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_enable_q <= 1'b0;
      begin_frame_q  <= '0;
      end_frame_q    <= '0;
      interval_min_q <= '0;
      interval_max_q <= '0;
      blink_length_q <= ebs_pkg::BLINK_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (ebs_pkg::cfg_index_e'(cfg_index_i))
        ebs_pkg::CFG_BLINK_ENABLE: blink_enable_q <= cfg_data_i[0];
        ebs_pkg::CFG_BEGIN_FRAME:  begin_frame_q  <= cfg_data_i;
        ebs_pkg::CFG_END_FRAME:    end_frame_q    <= cfg_data_i;
        ebs_pkg::CFG_INTERVAL_MIN: interval_min_q <= cfg_data_i[ebs_pkg::LEN_W-1:0];
        ebs_pkg::CFG_INTERVAL_MAX: interval_max_q <= cfg_data_i[ebs_pkg::LEN_W-1:0];
        ebs_pkg::CFG_BLINK_LENGTH: blink_length_q <= cfg_data_i[ebs_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Precompute sign and magnitude of the frame span and the interval range
  assign span_full  = {end_frame_q[31], end_frame_q} - {begin_frame_q[31], begin_frame_q};
  assign range_full = {1'b0, interval_max_q} - {1'b0, interval_min_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_mag_q  <= '0;
      span_neg_q  <= 1'b0;
      range_mag_q <= '0;
      range_neg_q <= 1'b0;
    end else begin
      span_neg_q  <= span_full[ebs_pkg::DATA_W];
      span_mag_q  <= span_full[ebs_pkg::DATA_W] ? ebs_pkg::DATA_W'(-span_full)
                                                 : span_full[ebs_pkg::DATA_W-1:0];
      range_neg_q <= range_full[ebs_pkg::DATA_W-1];
      range_mag_q <= range_full[ebs_pkg::DATA_W-1] ? ebs_pkg::LEN_W'(-range_full)
                                                    : range_full[ebs_pkg::LEN_W-1:0];
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      time_step_q   <= in_data_i[31:0];
      seen_value_q  <= in_data_i[63:32];
      random_unit_q <= in_data_i[79:64];
    end
  end

  // Check the seen value against begin and last published value
  assign seen_is_begin = (seen_value_q == begin_frame_q);
  assign seen_is_last  = (seen_value_q == last_q);

  always_comb begin
    ev_supp   = supp_q;
    ev_phase  = phase_q;
    ev_cur    = cur_q;
    ev_reload = 1'b0;
    if (supp_q && seen_is_begin) begin
      ev_supp   = 1'b0;
      ev_phase  = ebs_pkg::PH_IDLE;
      ev_cur    = begin_frame_q;
      ev_reload = 1'b1;
    end
    if (has_out_q && !seen_is_last) begin
      if (!seen_is_begin) begin
        ev_supp  = 1'b1;
        ev_phase = ebs_pkg::PH_IDLE;
        ev_cur   = seen_value_q;
      end else begin
        ev_supp   = 1'b0;
        ev_cur    = begin_frame_q;
        ev_reload = 1'b1;
      end
    end else if (!has_out_q && !seen_is_begin) begin
      ev_supp = 1'b1;
      ev_cur  = seen_value_q;
    end
    if (!ev_supp && wait_q[31]) begin
      ev_reload = 1'b1;
    end
  end

  // Countdown steps
  assign dt_pos      = !time_step_q[31] && (time_step_q != '0);
  assign wait_next   = sat_sub(wait_q, time_step_q);
  assign hold_next   = sat_sub(hold_q, time_step_q);
  assign wait_expire = wait_next[31] || (wait_next == '0);
  assign hold_expire = hold_next[31] || (hold_next == '0);

  // Wait reload: min plus floor of signed range times unit over 2^16
  assign rl_mag   = product_q[46:0];
  assign rl_prod  = range_neg_q ? 48'(-{1'b0, rl_mag}) : {1'b0, rl_mag};
  assign wait_new = {1'b0, interval_min_q} + rl_prod[47:16];

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      ebs_pkg::MUL_RELOAD: begin
        mul_a = {1'b0, range_mag_q};
        mul_b = {16'b0, random_unit_q};
      end
      ebs_pkg::MUL_RAMP: begin
        mul_a = span_mag_q;
        mul_b = {1'b0, time_step_q[30:0]};
      end
      ebs_pkg::MUL_HOLD: begin
        mul_a = {1'b0, blink_length_q};
        mul_b = ebs_pkg::RECIP5;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      product_q <= mul_a * mul_b;
    end
  end

  // Ramp step magnitude: span times step over length, saturating when large
  assign len      = (blink_length_q == '0) ? ebs_pkg::LEN_W'(1) : blink_length_q;
  assign ramp_big = ({1'b0, product_q[62:ebs_pkg::QUO_W]} >= len);

  ebs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_i      ({1'b0, product_q[62:ebs_pkg::QUO_W]}),
    .dividend_i (product_q[ebs_pkg::QUO_W-1:0]),
    .divisor_i  (len),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Apply the step toward end when closing, toward begin when opening
  assign opening  = (phase_q == ebs_pkg::PH_OPENING);
  assign add_pos  = (span_neg_q == opening);
  assign cur_ext  = {{3{cur_q[31]}}, cur_q};
  assign quo_ext  = {2'b00, quotient};
  assign ramp_sum = add_pos ? (cur_ext + quo_ext) : (cur_ext - quo_ext);

  always_comb begin
    if (ramp_big) begin
      ramp_next = add_pos ? ebs_pkg::S32_MAX : ebs_pkg::S32_MIN;
    end else begin
      ramp_next = sat35(ramp_sum);
    end
  end

  assign at_end_v    = span_neg_q ? (ramp_next <= end_frame_q) : (ramp_next >= end_frame_q);
  assign at_begin_v  = span_neg_q ? (ramp_next >= begin_frame_q)
                                  : (ramp_next <= begin_frame_q);
  assign ramp_arrive = opening ? at_begin_v : at_end_v;

  // Blink state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= ebs_pkg::PH_IDLE;
      cur_q         <= '0;
      wait_q        <= ebs_pkg::WAIT_RST;
      hold_q        <= '0;
      last_q        <= '0;
      supp_q        <= 1'b0;
      has_out_q     <= 1'b0;
      reload_pend_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        supp_q        <= ev_supp;
        phase_q       <= ev_phase;
        cur_q         <= ev_cur;
        reload_pend_q <= ev_reload;
      end
      if (cmd_i.reload_wr) begin
        wait_q <= wait_new;
      end
      if (cmd_i.wait_step && (cur_q == begin_frame_q)) begin
        wait_q <= wait_next;
        if (wait_expire) begin
          phase_q <= ebs_pkg::PH_CLOSING;
        end
      end
      if (cmd_i.hold_step) begin
        hold_q <= hold_next;
        if (hold_expire) begin
          phase_q <= ebs_pkg::PH_OPENING;
        end
      end
      if (cmd_i.ramp_upd) begin
        if (ramp_arrive) begin
          if (opening) begin
            cur_q   <= begin_frame_q;
            phase_q <= ebs_pkg::PH_IDLE;
          end else begin
            cur_q   <= end_frame_q;
            phase_q <= ebs_pkg::PH_HOLD;
          end
        end else begin
          cur_q <= ramp_next;
        end
      end
      if (cmd_i.hold_wr) begin
        hold_q <= {2'b00, product_q[ebs_pkg::PROD_W-1:ebs_pkg::RECIP5_SHIFT]};
      end
      if (cmd_i.res_load && blink_enable_q) begin
        if (supp_q) begin
          has_out_q <= 1'b0;
        end else begin
          has_out_q <= 1'b1;
          last_q    <= cur_q;
        end
      end
    end
  end

  // Output register: hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_pub_q  <= blink_enable_q && !supp_q;
      out_data_q <= (blink_enable_q && !supp_q) ? cur_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pub_o   = out_pub_q;
  assign out_data_o  = out_data_q;

  // Status toward the controller
  assign stat_o.enable      = blink_enable_q;
  assign stat_o.supp        = supp_q;
  assign stat_o.dt_pos      = dt_pos;
  assign stat_o.phase       = phase_q;
  assign stat_o.reload_pend = reload_pend_q;
  assign stat_o.hold_expire = hold_expire;
  assign stat_o.ramp_big    = ramp_big;
  assign stat_o.ramp_arrive = ramp_arrive;
  assign stat_o.div_busy    = div_busy;
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  // A reloaded wait is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.reload_wr |=> !wait_q[31])
    else $error("reloaded wait is negative");

  // Hold length is written only on entry to the hold phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hold_wr |=> (phase_q == ebs_pkg::PH_HOLD))
    else $error("hold written outside hold phase");

  // A pending published result matches the remembered last value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pub_q) |-> (out_data_q == last_q))
    else $error("published value differs from last value");
`endif

endmodule

@@ rtl/ebs_ctrl.sv @@
// Controller state machine of the eye blink sequencer: sequences evaluation,
// wait reload, countdown, ramp, hold setup and result steps. Depends on ebs_pkg.
module ebs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ebs_pkg::ebs_stat_t stat_i,
  output ebs_pkg::ebs_cmd_t  cmd_o
);

  ebs_pkg::ctl_state_e state_q, state_d;
  logic                post_q, post_d;
  ebs_pkg::ctl_state_e step_state;

  // Pick the per-phase step once the wait is loaded
  always_comb begin
    if (stat_i.supp || !stat_i.dt_pos) begin
      step_state = ebs_pkg::CS_RESULT;
    end else begin
      unique case (stat_i.phase)
        ebs_pkg::PH_IDLE: step_state = ebs_pkg::CS_WAIT_STEP;
        ebs_pkg::PH_HOLD: step_state = ebs_pkg::CS_HOLD_STEP;
        default:          step_state = ebs_pkg::CS_RMP_MUL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ebs_pkg::CS_IDLE;
      post_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      post_q  <= post_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    post_d     = post_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = ebs_pkg::MUL_RELOAD;
    unique case (state_q)
      ebs_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ebs_pkg::CS_EVAL;
        end
      end
      ebs_pkg::CS_EVAL: begin
        if (stat_i.enable) begin
          cmd_o.eval = 1'b1;
          state_d    = ebs_pkg::CS_PRE;
        end else begin
          state_d = ebs_pkg::CS_RESULT;
        end
      end
      ebs_pkg::CS_PRE: begin
        if (stat_i.reload_pend) begin
          post_d  = 1'b0;
          state_d = ebs_pkg::CS_RLD_MUL;
        end else begin
          state_d = step_state;
        end
      end
      ebs_pkg::CS_RLD_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = ebs_pkg::MUL_RELOAD;
        state_d       = ebs_pkg::CS_RLD_WR;
      end
      ebs_pkg::CS_RLD_WR: begin
        cmd_o.reload_wr = 1'b1;
        state_d         = post_q ? ebs_pkg::CS_RESULT : step_state;
      end
      ebs_pkg::CS_WAIT_STEP: begin
        cmd_o.wait_step = 1'b1;
        state_d         = ebs_pkg::CS_RESULT;
      end
      ebs_pkg::CS_HOLD_STEP: begin
        cmd_o.hold_step = 1'b1;
        if (stat_i.hold_expire) begin
          post_d  = 1'b1;
          state_d = ebs_pkg::CS_RLD_MUL;
        end else begin
          state_d = ebs_pkg::CS_RESULT;
        end
      end
      ebs_pkg::CS_RMP_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = ebs_pkg::MUL_RAMP;
        state_d       = ebs_pkg::CS_RMP_CHK;
      end
      ebs_pkg::CS_RMP_CHK: begin
        if (stat_i.ramp_big) begin
          state_d = ebs_pkg::CS_RMP_UPD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ebs_pkg::CS_RMP_DIV;
        end
      end
      ebs_pkg::CS_RMP_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ebs_pkg::CS_RMP_UPD;
        end
      end
      ebs_pkg::CS_RMP_UPD: begin
        cmd_o.ramp_upd = 1'b1;
        if (stat_i.ramp_arrive && (stat_i.phase == ebs_pkg::PH_CLOSING)) begin
          state_d = ebs_pkg::CS_HLD_MUL;
        end else begin
          state_d = ebs_pkg::CS_RESULT;
        end
      end
      ebs_pkg::CS_HLD_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = ebs_pkg::MUL_HOLD;
        state_d       = ebs_pkg::CS_HLD_WR;
      end
      ebs_pkg::CS_HLD_WR: begin
        cmd_o.hold_wr = 1'b1;
        state_d       = ebs_pkg::CS_RESULT;
      end
      ebs_pkg::CS_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ebs_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = ebs_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/eye_blink_sequencer_unit.sv @@
// Eye blink sequencer: one result per tick request. A disabled tick goes straight
// to the result; a ramp tick may also reload the wait, set up the hold and wait on
// the bit-serial ramp divider. Next request taken in the cycle after the result
// enters the output register, so no request is taken before the last one is done;
// the result waits while the result side stalls. Reset is asynchronous, active
// low; state clears at once. Top level; depends on ebs_pkg, ebs_ctrl, ebs_datapath.
module eye_blink_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: time_step[31:0], seen_value[63:32], random_unit[79:64]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ebs_pkg::IN_W-1:0]      s_axis_tdata,
  // tdata: frame_value[31:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ebs_pkg::DATA_W-1:0]    m_axis_tdata,
  // tuser: published[0]
  output logic                          m_axis_tuser,
  // configuration write port
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ebs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ebs_pkg::DATA_W-1:0]    cfg_data_i
);

  ebs_pkg::ebs_cmd_t  cmd;
  ebs_pkg::ebs_stat_t stat;

  // Sequencer
  ebs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  ebs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_pub_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

@@ tb/eye_blink_sequencer_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of eye_blink_sequencer_unit: directed and random tick requests,
// with a predictor of the blink cycle inside a small scoreboard class.
// Depends on ebs_pkg and the eye_blink_sequencer_unit RTL.
module eye_blink_sequencer_unit_test;
  import ebs_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint STEP_CLAMP = 64'sd1 << 40;

  typedef struct packed {
    logic              published;
    logic [DATA_W-1:0] frame_value;
  } blink_frame_t;

  // Predicts every tick result and checks the block's results in order
  class blink_frame_book;
    logic         enable;
    longint       begin_frm;
    longint       end_frm;
    longint       interval_lo;
    longint       interval_hi;
    longint       blink_len;
    blink_phase_e phase;
    longint       frame;
    longint       wait_left;
    longint       hold_left;
    longint       last_value;
    bit           suppressed;
    bit           has_output;
    blink_frame_t pending_frames[$];
    int           mismatches;

    function new();
      enable      = 1'b0;
      begin_frm   = 0;
      end_frm     = 0;
      interval_lo = 0;
      interval_hi = 0;
      blink_len   = 65536;
      phase       = PH_IDLE;
      frame       = 0;
      wait_left   = -1;
      hold_left   = 0;
      last_value  = 0;
      suppressed  = 1'b0;
      has_output  = 1'b0;
      mismatches  = 0;
    endfunction

    function longint clip32(longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
    endfunction

    // Draw a new wait between the interval limits, floor toward minus infinity
    function void reload_wait(logic [UNIT_W-1:0] unit);
      longint frac;
      longint prod;
      longint part;
      frac = unit;
      prod = (interval_hi - interval_lo) * frac;
      if (prod >= 0) part = prod / 65536;
      else part = -((-prod + 65535) / 65536);
      wait_left = clip32(interval_lo + part);
    endfunction

    function longint ramp_delta(longint dt);
      longint len;
      longint q;
      len = (blink_len != 0) ? blink_len : 1;
      q = ((end_frm - begin_frm) * dt) / len;
      if (q > STEP_CLAMP) q = STEP_CLAMP;
      if (q < -STEP_CLAMP) q = -STEP_CLAMP;
      return q;
    endfunction

    function bit reached_end(longint v);
      return (end_frm >= begin_frm) ? (v >= end_frm) : (v <= end_frm);
    endfunction

    function bit reached_begin(longint v);
      return (end_frm >= begin_frm) ? (v <= begin_frm) : (v >= begin_frm);
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_BLINK_ENABLE: enable = data[0];
        CFG_BEGIN_FRAME:  begin_frm = longint'($signed(data));
        CFG_END_FRAME:    end_frm = longint'($signed(data));
        CFG_INTERVAL_MIN: interval_lo = longint'(data[LEN_W-1:0]);
        CFG_INTERVAL_MAX: interval_hi = longint'(data[LEN_W-1:0]);
        CFG_BLINK_LENGTH: blink_len = longint'(data[LEN_W-1:0]);
        default: ;
      endcase
    endfunction

    // Value the driven variable shows outside when it follows the block
    function logic [DATA_W-1:0] feedback();
      return has_output ? last_value[DATA_W-1:0] : begin_frm[DATA_W-1:0];
    endfunction

    function void advance(longint dt, logic [UNIT_W-1:0] unit);
      case (phase)
        PH_IDLE: begin
          if (frame == begin_frm) begin
            wait_left = clip32(wait_left - dt);
            if (wait_left <= 0) phase = PH_CLOSING;
          end
        end
        PH_CLOSING: begin
          frame = clip32(frame + ramp_delta(dt));
          if (reached_end(frame)) begin
            frame     = end_frm;
            hold_left = blink_len / 5;
            phase     = PH_HOLD;
          end
        end
        PH_HOLD: begin
          hold_left = clip32(hold_left - dt);
          if (hold_left <= 0) begin
            reload_wait(unit);
            phase = PH_OPENING;
          end
        end
        default: begin
          frame = clip32(frame - ramp_delta(dt));
          if (reached_begin(frame)) begin
            frame = begin_frm;
            phase = PH_IDLE;
          end
        end
      endcase
    endfunction

    // Note one accepted tick request and queue its expected result
    function void note_tick(logic [DATA_W-1:0] dt_bits, logic [DATA_W-1:0] seen_bits,
                            logic [UNIT_W-1:0] unit);
      longint       dt;
      longint       seen;
      blink_frame_t res;
      dt   = longint'($signed(dt_bits));
      seen = longint'($signed(seen_bits));
      res  = '0;
      if (enable) begin
        // Outside value back at the open frame: leave suppression
        if (suppressed && seen == begin_frm) begin
          suppressed = 1'b0;
          phase      = PH_IDLE;
          frame      = begin_frm;
          reload_wait(unit);
        end
        // Outside value departed from what was published
        if (has_output && seen != last_value) begin
          if (seen != begin_frm) begin
            suppressed = 1'b1;
            phase      = PH_IDLE;
            frame      = seen;
          end else begin
            suppressed = 1'b0;
            frame      = begin_frm;
            reload_wait(unit);
          end
        end else if (!has_output && seen != begin_frm) begin
          suppressed = 1'b1;
          frame      = seen;
        end
        if (suppressed) begin
          has_output = 1'b0;
        end else begin
          if (wait_left < 0) reload_wait(unit);
          if (dt > 0) advance(dt, unit);
          last_value      = frame;
          has_output      = 1'b1;
          res.published   = 1'b1;
          res.frame_value = frame[DATA_W-1:0];
        end
      end
      pending_frames.insert(pending_frames.size(), res);
    endfunction

    function void check_frame(logic published, logic [DATA_W-1:0] value);
      blink_frame_t exp_frame;
      if (pending_frames.size() == 0) begin
        $error("result with no pending tick: published %0d frame_value %h", published, value);
        mismatches++;
        return;
      end
      exp_frame = pending_frames[0];
      pending_frames.delete(0);
      if (published !== exp_frame.published) begin
        $error("published: expected %0d, actual %0d", exp_frame.published, published);
        mismatches++;
      end
      if (value !== exp_frame.frame_value) begin
        $error("frame_value: expected %h, actual %h", exp_frame.frame_value, value);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_frames.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  blink_frame_book book = new();
  int              burst_left = 0;

  eye_blink_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side in modes: always ready, coin flip, mostly stalled
  initial begin : result_stall
    int unsigned mode;
    forever begin
      mode = $urandom_range(2);
      repeat (128) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(1));
          default: m_axis_tready <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_frame(m_axis_tuser, m_axis_tdata);
  end

  // End the run after too many cycles without any tick, result or configuration handshake
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop tick valid and wait until every expected result has come
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Send ticks in bursts of random length with random gaps between them
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(3) != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_tick(input logic [DATA_W-1:0] dt, input logic [DATA_W-1:0] seen,
                           input logic [UNIT_W-1:0] unit);
    pace();
    @(negedge clk_i);
    s_axis_tdata  <= {unit, seen, dt};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_tick(dt, seen, unit);
  endtask

  // Mostly follow the published value; sometimes jump back or away
  function automatic logic [DATA_W-1:0] pick_seen();
    int unsigned       r;
    logic [DATA_W-1:0] fb;
    r  = $urandom_range(99);
    fb = book.feedback();
    if (r < 82) return fb;
    if (r < 90) return book.begin_frm[DATA_W-1:0];
    if (r < 95) return fb + $urandom_range(1, 3);
    return $urandom();
  endfunction

  function automatic logic [DATA_W-1:0] pick_step(input int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 78) return $urandom_range(1, span);
    if (r < 84) return '0;
    if (r < 90) return 32'(0) - $urandom_range(1, span);
    if (r < 95) return $urandom();
    return r[0] ? S32_MAX : S32_MIN;
  endfunction

  task automatic run_phase(input logic [DATA_W-1:0] en, input logic [DATA_W-1:0] bgn,
                           input logic [DATA_W-1:0] fin, input logic [DATA_W-1:0] lo,
                           input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] len,
                           input int unsigned span, input int count);
    settle();
    write_reg(CFG_BLINK_ENABLE, en);
    write_reg(CFG_BEGIN_FRAME, bgn);
    write_reg(CFG_END_FRAME, fin);
    write_reg(CFG_INTERVAL_MIN, lo);
    write_reg(CFG_INTERVAL_MAX, hi);
    write_reg(CFG_BLINK_LENGTH, len);
    repeat (count) send_tick(pick_step(span), pick_seen(), 16'($urandom()));
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] bgn;
    logic [DATA_W-1:0] fin;
    logic [DATA_W-1:0] len;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: wait reload, zero and negative steps, step extremes, a full blink
    write_reg(CFG_BLINK_ENABLE, 32'h1);
    write_reg(CFG_BEGIN_FRAME, 32'h0001_0000);
    write_reg(CFG_END_FRAME, 32'h0005_0000);
    write_reg(CFG_INTERVAL_MIN, 32'h0);
    write_reg(CFG_INTERVAL_MAX, 32'h0002_0000);
    write_reg(CFG_BLINK_LENGTH, 32'h0002_0000);
    send_tick(32'h0000_0000, book.feedback(), 16'h0000);
    send_tick(32'hFFFF_FFFF, book.feedback(), 16'hFFFF);
    send_tick(S32_MIN, book.feedback(), 16'h0000);
    send_tick(32'h0001_0000, book.feedback(), 16'h0000);
    send_tick(S32_MAX, book.feedback(), 16'hFFFF);
    for (int k = 0; k < 10; k++) send_tick(32'h0000_8000, book.feedback(), 16'(k[0] ? 16'hFFFF : 0));
    // Departure, staying away, return to the open frame, departure at open frame
    send_tick(32'h0000_8000, S32_MAX, 16'h1234);
    send_tick(32'h0000_8000, S32_MIN, 16'h0000);
    send_tick(32'h0000_8000, book.begin_frm[DATA_W-1:0], 16'hFFFF);
    send_tick(32'h0001_0000, book.feedback(), 16'h8000);
    send_tick(32'h0001_0000, book.feedback() + 1, 16'h0001);
    send_tick(32'h0001_0000, book.begin_frm[DATA_W-1:0], 16'h7FFF);

    // Fixed settings: rising ramp, falling ramp with min above max, extremes
    run_phase(32'h1, 32'h0, 32'h0004_0000, 32'h0001_0000, 32'h0004_0000, 32'h0003_0000,
              32'h1_0000, 150);
    run_phase(32'h1, 32'h7FFF_0000, 32'h8001_0000, 32'h0003_0000, 32'h8000_8000, 32'h8000,
              32'h4000, 150);
    run_phase(32'h1, S32_MIN, S32_MAX, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF, 150);
    run_phase(32'hFFFF_FFFF, 32'hFFFE_0000, S32_MAX, 32'h0, 32'h0, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 120);
    // Zero blink length once, bit 31 of the length word set
    run_phase(32'h1, 32'h5, 32'hFFFF_FFFD, 32'h100, 32'h100, 32'h8000_0000, 32'h200, 120);
    // Disabled, with writes to the unused indexes
    settle();
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    run_phase(32'hFFFF_FFFE, $urandom(), $urandom(), 32'h100, 32'h200, 32'h400, 32'h200, 60);
    // Equal begin and end frames
    run_phase(32'h3, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h5, 8, 120);

    // Random settings, each frame small half the time so that blinks come often
    for (int k = 0; k < 4; k++) begin
      len = $urandom_range(1, 32'h6_0000);
      bgn = $urandom_range(1) ? $urandom() : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      fin = $urandom_range(1) ? $urandom() : $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      run_phase(32'h1 | ($urandom() & 32'hFFFF_FFFE), bgn, fin,
                $urandom_range(0, 32'h6_0000) | ($urandom() & 32'h8000_0000),
                $urandom_range(0, 32'h6_0000) | ($urandom() & 32'h8000_0000),
                len | ($urandom() & 32'h8000_0000), len / 2 + 1, 100);
    end

    settle();
    repeat (60) @(posedge clk_i);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ebs_pkg.sv
rtl/ebs_div.sv
rtl/ebs_datapath.sv
rtl/ebs_ctrl.sv
rtl/eye_blink_sequencer_unit.sv
tb/eye_blink_sequencer_unit_test.sv
